// ===== sv/brf_pkg.sv =====
// Shared types, constants and helper functions for the byte ring FIFO.
`default_nettype none
package brf_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = PTR_W + 1;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int OFF_W    = 9;
    localparam int CAP_W    = 9;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_REWIND = 3'd3,
        OP_COMMIT = 3'd4,
        OP_SEEK   = 3'd5,
        OP_FLUSH  = 3'd6
    } op_t;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_REFUSED = 2'd1;
    localparam status_t ST_EMPTY   = 2'd2;

    // capacity register clamped to 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] c;
        if (cap == '0)
            c = CNT_W'(1);
        else if (int'(cap) > DEPTH)
            c = CNT_W'(DEPTH);
        else
            c = CNT_W'(cap);
        return c;
    endfunction

    // pos < cap, k <= cap
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                  input logic [CNT_W-1:0] k,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] kk;
        logic [CNT_W-1:0] s;
        kk = (k == cap) ? '0 : k;
        s  = CNT_W'(pos) + kk;
        if (s >= cap)
            s = s - cap;
        return s[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/brf_if.sv =====
// Request and result channel interfaces for the byte ring FIFO.
`default_nettype none
interface brf_in_if;
    logic                            valid;
    logic                            ready;
    logic [brf_pkg::OP_W-1:0]        op;
    logic [brf_pkg::BYTE_W-1:0]      data_byte;
    logic [brf_pkg::LEN_W-1:0]       length;
    logic [brf_pkg::OFF_W-1:0]       offset;

    modport source (output valid, op, data_byte, length, offset, input ready);
    modport sink   (input valid, op, data_byte, length, offset, output ready);
endinterface

interface brf_out_if;
    logic                            valid;
    logic                            ready;
    logic [brf_pkg::BYTE_W-1:0]      read_byte;
    logic [brf_pkg::STAT_W-1:0]      status;
    logic                            last;
    logic [brf_pkg::COUNT_W-1:0]     used_count;
    logic [brf_pkg::COUNT_W-1:0]     free_count;
    logic [brf_pkg::COUNT_W-1:0]     peeked_count;
    logic                            empty_res;
    logic                            full_res;

    modport source (output valid, read_byte, status, last, used_count, free_count,
                    peeked_count, empty_res, full_res, input ready);
    modport sink   (input valid, read_byte, status, last, used_count, free_count,
                    peeked_count, empty_res, full_res, output ready);
endinterface
`default_nettype wire

// ===== sv/brf_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module brf_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/brf_ctrl.sv =====
// Pointer and count state, request decode, burst sequencer and result register.
`default_nettype none
module brf_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [brf_pkg::CAP_W-1:0]     cfg_wr_data,
    brf_in_if.sink                             in_ch,
    brf_out_if.source                          out_ch,
    output logic                               ram_we,
    output logic      [brf_pkg::PTR_W-1:0]     ram_waddr,
    output logic      [brf_pkg::BYTE_W-1:0]    ram_wdata,
    output logic                               ram_re,
    output logic      [brf_pkg::PTR_W-1:0]     ram_raddr,
    input  wire logic [brf_pkg::BYTE_W-1:0]    ram_rdata
);

    typedef enum logic {S_IDLE, S_BURST} state_t;

    state_t                          state_reg, state_next;
    logic [brf_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic [brf_pkg::PTR_W-1:0]       write_pos_reg, write_pos_next;
    logic [brf_pkg::PTR_W-1:0]       read_pos_reg, read_pos_next;
    logic [brf_pkg::PTR_W-1:0]       peek_pos_reg, peek_pos_next;
    logic [brf_pkg::CNT_W-1:0]       stored_reg, stored_next;
    logic [brf_pkg::CNT_W-1:0]       pdist_reg, pdist_next;
    logic                            refusing_reg, refusing_next;
    logic [brf_pkg::PTR_W-1:0]       pos_reg, pos_next;
    logic [brf_pkg::BURST_W-1:0]     rem_reg, rem_next;
    logic                            out_valid_reg, out_valid_next;
    logic [brf_pkg::BYTE_W-1:0]      out_byte_reg, out_byte_next;
    brf_pkg::status_t                out_status_reg, out_status_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            accept;
    logic                            load;
    logic [brf_pkg::CNT_W-1:0]       cap_eff;
    logic [brf_pkg::CNT_W-1:0]       free_cnt;
    logic [brf_pkg::LEN_W-1:0]       need;
    logic                            is_read;
    logic [brf_pkg::CNT_W-1:0]       avail;
    logic [brf_pkg::BURST_W-1:0]     len_clamp;
    logic [brf_pkg::BURST_W-1:0]     burst_n;
    logic [brf_pkg::PTR_W-1:0]       start_pos;
    logic [brf_pkg::PTR_W-1:0]       end_pos;
    logic [brf_pkg::CNT_W-1:0]       seek_d;
    logic [brf_pkg::PTR_W-1:0]       seek_pos;
    logic [brf_pkg::PTR_W-1:0]       pos_inc;
    logic [brf_pkg::PTR_W-1:0]       write_pos_inc;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign accept = in_ch.valid && in_ch.ready;

    assign cap_eff  = brf_pkg::eff_cap(cap_reg);
    assign free_cnt = cap_eff - stored_reg;
    assign need     = (in_ch.length == '0) ? brf_pkg::LEN_W'(1) : in_ch.length;
    assign is_read  = (in_ch.op == brf_pkg::OP_READ);
    assign avail    = is_read ? stored_reg : stored_reg - pdist_reg;

    assign len_clamp = (in_ch.length > brf_pkg::LEN_W'(brf_pkg::MAX_BURST))
                     ? brf_pkg::BURST_W'(brf_pkg::MAX_BURST)
                     : brf_pkg::BURST_W'(in_ch.length);
    assign burst_n   = (brf_pkg::CNT_W'(len_clamp) > avail)
                     ? brf_pkg::BURST_W'(avail) : len_clamp;

    assign start_pos = is_read ? read_pos_reg : peek_pos_reg;
    assign end_pos   = brf_pkg::wrap_add(start_pos, brf_pkg::CNT_W'(burst_n), cap_eff);
    assign seek_d    = (brf_pkg::CNT_W'(in_ch.offset) > stored_reg)
                     ? stored_reg : brf_pkg::CNT_W'(in_ch.offset);
    assign seek_pos  = brf_pkg::wrap_add(read_pos_reg, seek_d, cap_eff);
    assign pos_inc   = brf_pkg::wrap_add(pos_reg, brf_pkg::CNT_W'(1), cap_eff);
    assign write_pos_inc = brf_pkg::wrap_add(write_pos_reg, brf_pkg::CNT_W'(1), cap_eff);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        peek_pos_next   = peek_pos_reg;
        stored_next     = stored_reg;
        pdist_next      = pdist_reg;
        refusing_next   = refusing_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        load            = 1'b0;
        out_byte_next   = '0;
        out_status_next = brf_pkg::ST_OK;
        out_last_next   = 1'b1;
        ram_we          = 1'b0;
        ram_waddr       = write_pos_reg;
        ram_wdata       = in_ch.data_byte;
        ram_re          = 1'b0;
        ram_raddr       = start_pos;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    unique case (in_ch.op)
                        brf_pkg::OP_WRITE:
                        begin
                            if (refusing_reg)
                            begin
                                out_status_next = brf_pkg::ST_REFUSED;
                                if (in_ch.length <= brf_pkg::LEN_W'(1))
                                begin
                                    refusing_next = 1'b0;
                                end
                            end
                            else if (brf_pkg::CNT_W'(need) > free_cnt)
                            begin
                                out_status_next = brf_pkg::ST_REFUSED;
                                refusing_next   = (in_ch.length > brf_pkg::LEN_W'(1));
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                write_pos_next = write_pos_inc;
                                stored_next    = stored_reg + brf_pkg::CNT_W'(1);
                            end
                        end
                        brf_pkg::OP_READ, brf_pkg::OP_PEEK:
                        begin
                            if (avail == '0)
                            begin
                                out_status_next = brf_pkg::ST_EMPTY;
                            end
                            else if (burst_n != '0)
                            begin
                                // results follow from the burst sequencer
                                load       = 1'b0;
                                ram_re     = 1'b1;
                                pos_next   = start_pos;
                                rem_next   = burst_n;
                                state_next = S_BURST;
                                if (is_read)
                                begin
                                    read_pos_next = end_pos;
                                    stored_next   = stored_reg - brf_pkg::CNT_W'(burst_n);
                                    if (pdist_reg > brf_pkg::CNT_W'(burst_n))
                                    begin
                                        pdist_next = pdist_reg - brf_pkg::CNT_W'(burst_n);
                                    end
                                    else
                                    begin
                                        pdist_next    = '0;
                                        peek_pos_next = end_pos;
                                    end
                                end
                                else
                                begin
                                    peek_pos_next = end_pos;
                                    pdist_next    = pdist_reg + brf_pkg::CNT_W'(burst_n);
                                end
                            end
                        end
                        brf_pkg::OP_REWIND:
                        begin
                            peek_pos_next = read_pos_reg;
                            pdist_next    = '0;
                        end
                        brf_pkg::OP_COMMIT:
                        begin
                            read_pos_next = peek_pos_reg;
                            stored_next   = stored_reg - pdist_reg;
                            pdist_next    = '0;
                        end
                        brf_pkg::OP_SEEK:
                        begin
                            peek_pos_next = seek_pos;
                            pdist_next    = seek_d;
                        end
                        brf_pkg::OP_FLUSH:
                        begin
                            write_pos_next = '0;
                            read_pos_next  = '0;
                            peek_pos_next  = '0;
                            stored_next    = '0;
                            pdist_next     = '0;
                            refusing_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BURST:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = ram_rdata;
                    out_last_next = (rem_reg == brf_pkg::BURST_W'(1));
                    if (rem_reg == brf_pkg::BURST_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_inc;
                        pos_next  = pos_inc;
                        rem_next  = rem_reg - brf_pkg::BURST_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            cap_next       = cfg_wr_data;
            write_pos_next = '0;
            read_pos_next  = '0;
            peek_pos_next  = '0;
            stored_next    = '0;
            pdist_next     = '0;
            refusing_next  = 1'b0;
        end
    end

    assign out_valid_next = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= brf_pkg::CAP_RESET;
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            peek_pos_reg   <= '0;
            stored_reg     <= '0;
            pdist_reg      <= '0;
            refusing_reg   <= 1'b0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_status_reg <= brf_pkg::ST_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            peek_pos_reg   <= peek_pos_next;
            stored_reg     <= stored_next;
            pdist_reg      <= pdist_next;
            refusing_reg   <= refusing_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
            if (load)
            begin
                out_byte_reg   <= out_byte_next;
                out_status_reg <= out_status_next;
                out_last_reg   <= out_last_next;
            end
        end
    end

    // occupancy is live state: it only changes on a new request or a config write
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.read_byte    = out_byte_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.last         = out_last_reg;
    assign out_ch.used_count   = brf_pkg::COUNT_W'(stored_reg);
    assign out_ch.free_count   = brf_pkg::COUNT_W'(free_cnt);
    assign out_ch.peeked_count = brf_pkg::COUNT_W'(pdist_reg);
    assign out_ch.empty_res    = (stored_reg == '0);
    assign out_ch.full_res     = (stored_reg == cap_eff);

    a_stored_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= cap_eff)
        else $error("stored count exceeds capacity");

    a_pdist_le_stored: assert property (@(posedge clk) disable iff (!rst_n)
        pdist_reg <= stored_reg)
        else $error("peek distance exceeds stored count");

    a_peek_tracks_read: assert property (@(posedge clk) disable iff (!rst_n)
        peek_pos_reg == brf_pkg::wrap_add(read_pos_reg, pdist_reg, cap_eff))
        else $error("peek pointer out of step with read pointer");

    a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BURST |-> rem_reg != '0)
        else $error("burst with nothing remaining");

    a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BURST && out_free && rem_reg == brf_pkg::BURST_W'(1)
        |=> out_valid_reg && out_last_reg && state_reg == S_IDLE)
        else $error("burst end did not flag last");

endmodule
`default_nettype wire

// ===== sv/byte_ring_fifo_with_peek.sv =====
// Byte ring FIFO with peek pointer: top level.
//
// Requests arrive on in_ch (valid/ready); each carries op, data_byte, length
// and offset. Results leave on out_ch (valid/ready), one per write, rewind,
// commit, seek, flush or unused op, and one per byte for a read or peek burst
// (last marks the final result of a request). Every result carries the
// occupancy after the whole request.
// A single-result request shows its result in the cycle after it is taken.
// Read or peek bytes pass the registered RAM read, then the result register.
// One request is worked at a time; a burst ends before the next is taken.
// While the receiver is ready, single-result requests go at one per cycle
// and burst bytes at one byte per cycle. The user must write the capacity
// register through cfg_wr_en/cfg_wr_data only while idle (not enforced);
// a write also empties the FIFO. Reset empties the FIFO and sets capacity
// to 256; RAM contents are not cleared. When the receiver stalls, the result
// register holds and no new request or burst byte advances.
`default_nettype none
module byte_ring_fifo_with_peek (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [brf_pkg::CAP_W-1:0]     cfg_wr_data,
    brf_in_if.sink                             in_ch,
    brf_out_if.source                          out_ch
);

    logic                          ram_we;
    logic [brf_pkg::PTR_W-1:0]     ram_waddr;
    logic [brf_pkg::BYTE_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [brf_pkg::PTR_W-1:0]     ram_raddr;
    logic [brf_pkg::BYTE_W-1:0]    ram_rdata;

    brf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    brf_ram #(
        .DATA_W (brf_pkg::BYTE_W),
        .ADDR_W (brf_pkg::PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== dv/byte_ring_fifo_with_peek_tb.sv =====
// Self-checking testbench for the byte ring FIFO with peek pointer.
module byte_ring_fifo_with_peek_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES    = 200;
    localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [brf_pkg::OP_W-1:0]   op;
        logic [brf_pkg::BYTE_W-1:0] data_byte;
        logic [brf_pkg::LEN_W-1:0]  length;
        logic [brf_pkg::OFF_W-1:0]  offset;
    } fifo_req_t;

    typedef struct packed {
        logic [brf_pkg::BYTE_W-1:0]  read_byte;
        brf_pkg::status_t            status;
        logic                        last;
        logic [brf_pkg::COUNT_W-1:0] used_count;
        logic [brf_pkg::COUNT_W-1:0] free_count;
        logic [brf_pkg::COUNT_W-1:0] peeked_count;
        logic                        empty_res;
        logic                        full_res;
    } fifo_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [brf_pkg::CAP_W-1:0] cfg_wr_data;

    brf_in_if  in_ch ();
    brf_out_if out_ch ();

    byte_ring_fifo_with_peek u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow FIFO state
    logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::DEPTH];
    logic [brf_pkg::PTR_W-1:0]  wr_ptr;
    logic [brf_pkg::PTR_W-1:0]  rd_ptr;
    logic [brf_pkg::PTR_W-1:0]  pk_ptr;
    logic [brf_pkg::CNT_W-1:0]  fill_level;
    logic [brf_pkg::CNT_W-1:0]  peek_span;
    logic                       refusing;
    logic [brf_pkg::CAP_W-1:0]  cap_reg;

    fifo_req_t    pending_requests [$];
    fifo_result_t expected_results [$];
    fifo_req_t    cur_req;

    int  error_count     = 0;
    int  requests_taken  = 0;
    int  results_checked = 0;
    int  cap_writes      = 0;
    int  send_gap        = 0;
    int  rx_stall        = 0;
    bit  idling_on       = 1'b1;
    bit  hold_start      = 1'b0;
    logic rx_hold        = 1'b0;

    function automatic int unsigned eff_capacity();
        if (cap_reg == '0)
            return 1;
        if (int'(cap_reg) > brf_pkg::DEPTH)
            return brf_pkg::DEPTH;
        return int'(cap_reg);
    endfunction

    function automatic logic [brf_pkg::PTR_W-1:0] ring_add(
            input logic [brf_pkg::PTR_W-1:0] pos, input int unsigned k);
        int unsigned c;
        int unsigned s;
        c = eff_capacity();
        s = (32'(pos) % c) + (k % c);
        if (s >= c)
            s = s - c;
        return s[brf_pkg::PTR_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic clear_fifo_state();
        wr_ptr     = '0;
        rd_ptr     = '0;
        pk_ptr     = '0;
        fill_level = '0;
        peek_span  = '0;
        refusing   = 1'b0;
    endtask

    task automatic push_result(input logic [brf_pkg::BYTE_W-1:0] b,
                               input brf_pkg::status_t st, input logic lst);
        fifo_result_t r;
        int unsigned  c;
        c              = eff_capacity();
        r.read_byte    = b;
        r.status       = st;
        r.last         = lst;
        r.used_count   = fill_level;
        r.free_count   = brf_pkg::COUNT_W'(c - 32'(fill_level));
        r.peeked_count = peek_span;
        r.empty_res    = (fill_level == '0);
        r.full_res     = (32'(fill_level) == c);
        expected_results.push_back(r);
    endtask

    task automatic predict_request(input fifo_req_t q);
        logic [brf_pkg::BYTE_W-1:0] burst [$];
        logic [brf_pkg::PTR_W-1:0]  pos;
        logic [brf_pkg::CNT_W-1:0]  n_cnt;
        int unsigned                c;
        int unsigned                need;
        int unsigned                avail;
        int unsigned                n;
        c = eff_capacity();
        case (q.op)
            brf_pkg::OP_WRITE:
            begin
                need = (q.length == '0) ? 1 : 32'(q.length);
                if (refusing)
                begin
                    if (q.length <= brf_pkg::LEN_W'(1))
                        refusing = 1'b0;
                    push_result('0, brf_pkg::ST_REFUSED, 1'b1);
                end
                else if (need > c - 32'(fill_level))
                begin
                    refusing = (q.length > brf_pkg::LEN_W'(1));
                    push_result('0, brf_pkg::ST_REFUSED, 1'b1);
                end
                else
                begin
                    ring_mem[wr_ptr] = q.data_byte;
                    wr_ptr           = ring_add(wr_ptr, 1);
                    fill_level       = fill_level + brf_pkg::CNT_W'(1);
                    push_result('0, brf_pkg::ST_OK, 1'b1);
                end
            end
            brf_pkg::OP_READ, brf_pkg::OP_PEEK:
            begin
                avail = (q.op == brf_pkg::OP_READ) ? 32'(fill_level)
                                                   : 32'(fill_level - peek_span);
                pos   = (q.op == brf_pkg::OP_READ) ? rd_ptr : pk_ptr;
                n     = 32'(q.length);
                if (n > 32'(brf_pkg::MAX_BURST))
                    n = 32'(brf_pkg::MAX_BURST);
                if (n > avail)
                    n = avail;
                if (avail == 0)
                    push_result('0, brf_pkg::ST_EMPTY, 1'b1);
                else if (n == 0)
                    push_result('0, brf_pkg::ST_OK, 1'b1);
                else
                begin
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        burst.push_back(ring_mem[pos]);
                        pos = ring_add(pos, 1);
                    end
                    n_cnt = brf_pkg::CNT_W'(n);
                    if (q.op == brf_pkg::OP_READ)
                    begin
                        rd_ptr     = pos;
                        fill_level = fill_level - n_cnt;
                        peek_span  = (peek_span > n_cnt) ? peek_span - n_cnt : '0;
                        pk_ptr     = ring_add(rd_ptr, 32'(peek_span));
                    end
                    else
                    begin
                        pk_ptr    = pos;
                        peek_span = peek_span + n_cnt;
                    end
                    foreach (burst[i])
                        push_result(burst[i], brf_pkg::ST_OK, (i == burst.size() - 1));
                end
            end
            brf_pkg::OP_REWIND:
            begin
                pk_ptr    = rd_ptr;
                peek_span = '0;
                push_result('0, brf_pkg::ST_OK, 1'b1);
            end
            brf_pkg::OP_COMMIT:
            begin
                rd_ptr     = pk_ptr;
                fill_level = fill_level - peek_span;
                peek_span  = '0;
                push_result('0, brf_pkg::ST_OK, 1'b1);
            end
            brf_pkg::OP_SEEK:
            begin
                peek_span = (brf_pkg::CNT_W'(q.offset) > fill_level)
                          ? fill_level : brf_pkg::CNT_W'(q.offset);
                pk_ptr    = ring_add(rd_ptr, 32'(peek_span));
                push_result('0, brf_pkg::ST_OK, 1'b1);
            end
            brf_pkg::OP_FLUSH:
            begin
                clear_fifo_state();
                push_result('0, brf_pkg::ST_OK, 1'b1);
            end
            default:
                push_result('0, brf_pkg::ST_OK, 1'b1);
        endcase
    endtask

    task automatic queue_req(input logic [brf_pkg::OP_W-1:0] op,
                             input logic [brf_pkg::BYTE_W-1:0] d,
                             input logic [brf_pkg::LEN_W-1:0] len,
                             input logic [brf_pkg::OFF_W-1:0] off);
        fifo_req_t q;
        q.op        = op;
        q.data_byte = d;
        q.length    = len;
        q.offset    = off;
        pending_requests.push_back(q);
    endtask

    task automatic queue_rand(input logic [brf_pkg::OP_W-1:0] op,
                              input logic [brf_pkg::LEN_W-1:0] len);
        queue_req(op, brf_pkg::BYTE_W'($urandom_range(0, 255)), len,
                  brf_pkg::OFF_W'($urandom_range(0, 511)));
    endtask

    // one write call of nbytes; stops after keep items when keep < nbytes
    task automatic queue_write_call(input int nbytes, input int keep);
        for (int k = nbytes; k > nbytes - keep && k >= 1; k--)
            queue_rand(brf_pkg::OP_WRITE, brf_pkg::LEN_W'(k));
    endtask

    task automatic write_capacity(input logic [brf_pkg::CAP_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_reg = v;
        clear_fifo_state();
        cap_writes++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random_phase(input logic [brf_pkg::CAP_W-1:0] cap_value,
                                    input int nitems, input bit idle);
        int unsigned c;
        int          start;
        int          r;
        int          nb;
        write_capacity(cap_value);
        idling_on = idle;
        c     = eff_capacity();
        start = pending_requests.size();
        while (pending_requests.size() - start < nitems)
        begin
            r = $urandom_range(0, 99);
            if (r < 36)
            begin
                nb = $urandom_range(1, (c < 6) ? c : 6);
                queue_write_call(nb, nb);
            end
            else if (r < 40)
            begin
                // call larger than the capacity when that is under 127, else 127 bytes
                nb = (c >= 127) ? 127 : int'(c) + 1;
                if (nb <= 8)
                    queue_write_call(nb, nb);
                else
                begin
                    queue_rand(brf_pkg::OP_WRITE, brf_pkg::LEN_W'(nb));
                    queue_rand(brf_pkg::OP_WRITE, brf_pkg::LEN_W'(1));
                end
            end
            else if (r < 70)
            begin
                case ($urandom_range(0, 9))
                    0:       nb = 0;
                    1:       nb = $urandom_range(60, 127);
                    default: nb = $urandom_range(1, 8);
                endcase
                queue_rand((r < 56) ? brf_pkg::OP_READ : brf_pkg::OP_PEEK,
                           brf_pkg::LEN_W'(nb));
            end
            else if (r < 78)
                queue_req(brf_pkg::OP_SEEK, brf_pkg::BYTE_W'($urandom_range(0, 255)),
                          brf_pkg::LEN_W'($urandom_range(0, 127)),
                          brf_pkg::OFF_W'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 511)
                                          : $urandom_range(0, 8)));
            else if (r < 84)
                queue_rand(brf_pkg::OP_REWIND, brf_pkg::LEN_W'($urandom_range(0, 127)));
            else if (r < 90)
                queue_rand(brf_pkg::OP_COMMIT, brf_pkg::LEN_W'($urandom_range(0, 127)));
            else if (r < 93)
                queue_rand(brf_pkg::OP_FLUSH, brf_pkg::LEN_W'($urandom_range(0, 127)));
            else if (r < 96)
                queue_rand(OP_UNUSED, brf_pkg::LEN_W'($urandom_range(0, 127)));
            else
            begin
                // call abandoned before its last byte
                nb = $urandom_range(3, 8);
                queue_write_call(nb, $urandom_range(1, 2));
            end
        end
        wait_idle();
    endtask

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : request_driver
        logic offer;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_request(cur_req);
                requests_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                offer = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_requests.size() > 0)
                begin
                    cur_req          = pending_requests.pop_front();
                    offer            = 1'b1;
                    in_ch.op        <= cur_req.op;
                    in_ch.data_byte <= cur_req.data_byte;
                    in_ch.length    <= cur_req.length;
                    in_ch.offset    <= cur_req.offset;
                    send_gap         = pick_gap();
                end
                in_ch.valid <= offer;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        fifo_result_t e;
        logic         nr;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: read_byte %0d status %0d",
                           out_ch.read_byte, out_ch.status);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("read_byte", 9'(e.read_byte), 9'(out_ch.read_byte));
                    check_field("status", 9'(e.status), 9'(out_ch.status));
                    check_field("last", 9'(e.last), 9'(out_ch.last));
                    check_field("used_count", e.used_count, out_ch.used_count);
                    check_field("free_count", e.free_count, out_ch.free_count);
                    check_field("peeked_count", e.peeked_count, out_ch.peeked_count);
                    check_field("empty_res", 9'(e.empty_res), 9'(out_ch.empty_res));
                    check_field("full_res", 9'(e.full_res), 9'(out_ch.full_res));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                nr = 1'b0;
            end
            else
            begin
                nr = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
            out_ch.ready <= nr && !rx_hold;
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin : rx_holdoff
        wait (hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("byte_ring_fifo_with_peek_tb: errors");
        $finish;
    end

    initial
    begin : main_seq
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = '0;
        in_ch.data_byte = '0;
        in_ch.length    = '0;
        in_ch.offset    = '0;
        out_ch.ready    = 1'b0;
        cap_reg         = brf_pkg::CAP_RESET;
        clear_fifo_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty reads, a write call, peek limits, rewind, seek, commit, unused op, flush
        queue_req(brf_pkg::OP_READ,   8'h00, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'hFF, 7'd127, 9'd511);
        queue_req(brf_pkg::OP_WRITE,  8'h00, 7'd3,   9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'hFF, 7'd2,   9'd511);
        queue_req(brf_pkg::OP_WRITE,  8'hA5, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'h5A, 7'd0,   9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'h00, 7'd0,   9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'h00, 7'd2,   9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'h00, 7'd127, 9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'h00, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_REWIND, 8'h00, 7'd0,   9'd0);
        queue_req(brf_pkg::OP_SEEK,   8'h00, 7'd0,   9'd511);
        queue_req(brf_pkg::OP_SEEK,   8'h00, 7'd0,   9'd1);
        queue_req(brf_pkg::OP_READ,   8'h00, 7'd2,   9'd0);
        queue_req(brf_pkg::OP_PEEK,   8'h00, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_COMMIT, 8'h00, 7'd0,   9'd0);
        queue_req(brf_pkg::OP_READ,   8'h00, 7'd0,   9'd0);
        queue_req(OP_UNUSED,          8'hFF, 7'd127, 9'd511);
        queue_req(brf_pkg::OP_FLUSH,  8'h00, 7'd0,   9'd0);
        queue_req(brf_pkg::OP_READ,   8'h00, 7'd64,  9'd0);
        wait_idle();

        // capacity zero acts as one slot: full, then refused calls
        write_capacity(9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'h81, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'h7E, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'h11, 7'd2,   9'd0);
        queue_req(brf_pkg::OP_WRITE,  8'h22, 7'd1,   9'd0);
        queue_req(brf_pkg::OP_READ,   8'h00, 7'd1,   9'd0);
        wait_idle();

        run_random_phase(9'd511, 14, 1'b1);
        run_random_phase(9'd1, 12, 1'b1);
        run_random_phase(9'd3, 14, 1'b0);

        // fill a small FIFO while the receiver holds off
        write_capacity(9'd16);
        idling_on  = 1'b1;
        hold_start = 1'b1;
        queue_write_call(10, 10);
        queue_write_call(10, 10);
        queue_rand(brf_pkg::OP_READ, 7'd8);
        queue_rand(brf_pkg::OP_PEEK, 7'd4);
        queue_rand(brf_pkg::OP_COMMIT, 7'd0);
        queue_write_call(5, 5);
        queue_rand(brf_pkg::OP_READ, 7'd64);
        wait_idle();

        run_random_phase(brf_pkg::CAP_W'($urandom_range(4, 40)), 14, 1'b1);
        run_random_phase(9'd256, 14, 1'b1);

        $display("covered %0d requests and %0d results over %0d capacity settings,",
                 requests_taken, results_checked, cap_writes);
        $display("including wraparound, refused calls, peek/seek/commit and a full stall");
        if (error_count == 0)
            $display("byte_ring_fifo_with_peek_tb: clean");
        else
            $display("byte_ring_fifo_with_peek_tb: errors");
        $finish;
    end

endmodule
